FILE: hw/rtl/pac_pkg.sv
// ----------------------------------------------------------------------------
// pac_pkg
// Shared types, constants and the control program of the pitot airspeed
// conversion unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pac_pkg;

    // Field widths.
    localparam int TS_W    = 32;
    localparam int PCNT_W  = 14;
    localparam int TCNT_W  = 11;
    localparam int RHO_W   = 11;
    localparam int SPEED_W = 15;
    localparam int TEMP_W  = 15;

    // Datapath widths.
    localparam int DEN_W  = 25;   // 16383 * rho
    localparam int NUM_W  = 52;   // speed constant * |d|
    localparam int QUO_W  = 29;   // speed squared in (cm/s)^2
    localparam int ROOT_W = 30;   // square root operands
    localparam int TN_W   = 26;   // 20000 * t + 1023
    localparam int TPR_W  = 43;   // TN times reciprocal
    localparam int TPR_SH = 27;

    localparam logic [RHO_W-1:0]   RHO_RESET   = 11'd1225;
    localparam logic [RHO_W-1:0]   RHO_MIN     = 11'd500;
    localparam logic [RHO_W-1:0]   RHO_MAX     = 11'd2000;
    localparam logic [PCNT_W:0]    COUNT_SPAN  = 15'd16383;
    localparam logic [37:0]        SPEED_K     = 38'd172368925000; // 25000 * 6894757
    localparam logic [SPEED_W-1:0] SPEED_LIMIT = 15'd12000;
    localparam logic [14:0]        TEMP_SCALE  = 15'd20000;
    localparam logic [10:0]        TEMP_ROUND  = 11'd1023;
    localparam logic [TCNT_W-1:0]  TEMP_DIV    = 11'd2047;
    localparam logic [16:0]        TEMP_RECIP  = 17'd65568;   // floor(2^27 / 2047)
    localparam logic [TEMP_W-1:0]  TEMP_BIAS   = 15'd5000;
    localparam logic [4:0]         DIV_STEPS   = 5'd28;       // loop count minus one
    localparam logic [4:0]         ROOT_STEPS  = 5'd14;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_MUL,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_ROOT_INIT,
        OP_ROOT_STEP,
        OP_STORE
    } t_op;

    typedef enum logic [1:0] {
        JMP_NEXT,       // advance, load the loop counter from the word
        JMP_LOOP,       // repeat while the loop counter is nonzero
        JMP_WAIT_IN,    // hold until an input transfer
        JMP_WAIT_OUT    // hold until the output register is free, then jump
    } t_jmp;

    typedef struct packed {
        t_op        op;
        t_jmp       jmp;
        logic [4:0] count;
        logic [2:0] target;
    } t_uword;

    localparam logic [2:0] PC_IDLE      = 3'd0;
    localparam logic [2:0] PC_MUL       = 3'd1;
    localparam logic [2:0] PC_DIV_INIT  = 3'd2;
    localparam logic [2:0] PC_DIV_STEP  = 3'd3;
    localparam logic [2:0] PC_ROOT_INIT = 3'd4;
    localparam logic [2:0] PC_ROOT_STEP = 3'd5;
    localparam logic [2:0] PC_STORE     = 3'd6;

    // Control program, one word per step.
    function automatic t_uword pac_uprog(input logic [2:0] pc);
        t_uword w;
        w = '{op: OP_IDLE, jmp: JMP_WAIT_IN, count: 5'd0, target: PC_IDLE};
        unique case (pc)
            PC_IDLE:      w = '{op: OP_IDLE,      jmp: JMP_WAIT_IN,  count: 5'd0,
                                target: PC_IDLE};
            PC_MUL:       w = '{op: OP_MUL,       jmp: JMP_NEXT,     count: 5'd0,
                                target: PC_IDLE};
            PC_DIV_INIT:  w = '{op: OP_DIV_INIT,  jmp: JMP_NEXT,     count: DIV_STEPS,
                                target: PC_IDLE};
            PC_DIV_STEP:  w = '{op: OP_DIV_STEP,  jmp: JMP_LOOP,     count: 5'd0,
                                target: PC_IDLE};
            PC_ROOT_INIT: w = '{op: OP_ROOT_INIT, jmp: JMP_NEXT,     count: ROOT_STEPS,
                                target: PC_IDLE};
            PC_ROOT_STEP: w = '{op: OP_ROOT_STEP, jmp: JMP_LOOP,     count: 5'd0,
                                target: PC_IDLE};
            PC_STORE:     w = '{op: OP_STORE,     jmp: JMP_WAIT_OUT, count: 5'd0,
                                target: PC_IDLE};
            default:      w = '{op: OP_IDLE,      jmp: JMP_WAIT_IN,  count: 5'd0,
                                target: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pitot_airspeed_conversion_unit.sv
// ----------------------------------------------------------------------------
// pitot_airspeed_conversion_unit
// Converts one differential pressure sensor sample into elapsed time,
// signed indicated airspeed and temperature.
// ----------------------------------------------------------------------------
// Usage:
//   Samples arrive on the input channel (i_in_valid / o_in_ready). Each
//   sample gives one result on the output channel (o_out_valid /
//   i_out_ready). The air density register is written through the
//   configuration channel, which is always ready; write it only while idle.
//   A small microcoded sequencer drives a shared datapath: one multiply
//   step, a radix-2 divider of 29 steps for speed squared, and a square
//   root of 15 steps. The temperature division by 2047 runs alongside as a
//   reciprocal multiply with one correction.
//   A new sample is taken only once the current one has run through the
//   divider and root loops and been stored in the output register.
//   A finished result waits in the output register while the next sample
//   is accepted and processed. If the receiver stalls, the sequencer holds
//   in its last step until the output register is free.
//   Reset returns the sequencer to idle, drops o_out_valid, sets the air
//   density to 1.225 kg/m^3 and the time origin to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pitot_airspeed_conversion_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [pac_pkg::RHO_W-1:0]         i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [pac_pkg::TS_W-1:0]          i_timestamp_us,
    input  wire logic [pac_pkg::PCNT_W-1:0]        i_pressure_count,
    input  wire logic [pac_pkg::TCNT_W-1:0]        i_temperature_count,
    input  wire logic                              i_start_of_run,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [pac_pkg::TS_W-1:0]               o_elapsed_us,
    output logic signed [pac_pkg::SPEED_W-1:0]     o_airspeed_cm_s,
    output logic signed [pac_pkg::TEMP_W-1:0]      o_temperature_centi_c
);
    import pac_pkg::*;

    // Sequencer.
    logic [2:0] r_pc, n_pc;
    logic [4:0] r_cnt, n_cnt;
    t_uword     w_uop;

    // State and datapath registers.
    logic [RHO_W-1:0]   r_density;
    logic [TS_W-1:0]    r_origin;
    logic [TS_W-1:0]    r_elapsed;
    logic               r_neg;
    logic [PCNT_W-1:0]  r_mag;
    logic [DEN_W-1:0]   r_den;
    logic [TN_W-1:0]    r_tn;
    logic [NUM_W-1:0]   r_num;
    logic [TPR_W-1:0]   r_tprod;
    logic [DEN_W-1:0]   r_rem;
    logic [QUO_W-1:0]   r_quo;
    logic [TEMP_W-1:0]  r_tq;
    logic [TEMP_W-1:0]  r_temp;
    logic [ROOT_W-1:0]  r_x;
    logic [ROOT_W-1:0]  r_res;
    logic [ROOT_W-1:0]  r_bit;

    logic                       r_out_valid;
    logic [TS_W-1:0]            r_out_elapsed;
    logic [SPEED_W-1:0]         r_out_speed;
    logic [TEMP_W-1:0]          r_out_temp;

    logic w_in_xfer;
    logic w_out_free;

    // Input conversion.
    logic [PCNT_W:0]    w_twice_p;
    logic [PCNT_W:0]    w_mag_full;
    logic               w_neg;
    logic [RHO_W-1:0]   w_rho;
    logic [DEN_W-1:0]   w_den;
    logic [TN_W-1:0]    w_tn;
    logic [NUM_W-1:0]   w_num;
    logic [TPR_W-1:0]   w_tprod;

    // Divider step.
    logic [DEN_W:0]     w_shift;
    logic               w_ge;
    logic [DEN_W:0]     w_diff;
    logic [DEN_W-1:0]   w_rem_nx;

    // Square root step.
    logic [ROOT_W:0]    w_trial;
    logic               w_take;

    // Temperature correction.
    logic [TN_W-1:0]    w_tq_mul;
    logic [TN_W-1:0]    w_trem;
    logic [TEMP_W-1:0]  w_tq_fix;

    // Result assembly.
    logic [SPEED_W-1:0] w_spd;
    logic [SPEED_W-1:0] w_sat;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_pc == PC_IDLE);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_uop       = pac_uprog(r_pc);

    // d = 16383 - 2p as sign and magnitude; d is always odd.
    assign w_twice_p  = {i_pressure_count, 1'b0};
    assign w_neg      = (w_twice_p >= COUNT_SPAN);
    assign w_mag_full = w_neg ? (w_twice_p - COUNT_SPAN) : (COUNT_SPAN - w_twice_p);

    always_comb begin
        priority if (r_density < RHO_MIN) begin
            w_rho = RHO_MIN;
        end else if (r_density > RHO_MAX) begin
            w_rho = RHO_MAX;
        end else begin
            w_rho = r_density;
        end
    end

    // 16383 * rho as a shift and subtract.
    assign w_den   = {w_rho, {PCNT_W{1'b0}}} - DEN_W'(w_rho);
    assign w_tn    = TN_W'(i_temperature_count) * TN_W'(TEMP_SCALE) + TN_W'(TEMP_ROUND);
    assign w_num   = NUM_W'(r_mag) * NUM_W'(SPEED_K);
    assign w_tprod = TPR_W'(r_tn) * TPR_W'(TEMP_RECIP);

    // Restoring division; the quotient register doubles as dividend shifter.
    assign w_shift  = {r_rem, r_quo[QUO_W-1]};
    assign w_ge     = (w_shift >= {1'b0, r_den});
    assign w_diff   = w_shift - {1'b0, r_den};
    assign w_rem_nx = w_ge ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];

    // Bit-pair square root.
    assign w_trial = {1'b0, r_res} + {1'b0, r_bit};
    assign w_take  = ({1'b0, r_x} >= w_trial);

    // The reciprocal estimate is the quotient or one below it.
    assign w_tq_mul = {r_tq, {TCNT_W{1'b0}}} - TN_W'(r_tq);
    assign w_trem   = r_tn - w_tq_mul;
    assign w_tq_fix = (w_trem >= TN_W'(TEMP_DIV)) ? (r_tq + 1'b1) : r_tq;

    assign w_spd = r_res[SPEED_W-1:0];
    assign w_sat = (w_spd > SPEED_LIMIT) ? SPEED_LIMIT : w_spd;

    // Step counter and loop counter.
    always_comb begin
        n_pc  = r_pc;
        n_cnt = r_cnt;
        unique case (w_uop.jmp)
            JMP_WAIT_IN: begin
                if (i_in_valid) begin
                    n_pc = r_pc + 3'd1;
                end
            end
            JMP_NEXT: begin
                n_pc  = r_pc + 3'd1;
                n_cnt = w_uop.count;
            end
            JMP_LOOP: begin
                if (r_cnt != 5'd0) begin
                    n_cnt = r_cnt - 5'd1;
                end else begin
                    n_pc = r_pc + 3'd1;
                end
            end
            JMP_WAIT_OUT: begin
                if (w_out_free) begin
                    n_pc = w_uop.target;
                end
            end
            default: begin
                n_pc = PC_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= PC_IDLE;
            r_cnt <= 5'd0;
        end else begin
            r_pc  <= n_pc;
            r_cnt <= n_cnt;
        end
    end

    // Configuration register and time origin.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_density <= RHO_RESET;
            r_origin  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_density <= i_cfg_data;
            end
            if (w_in_xfer && i_start_of_run) begin
                r_origin <= i_timestamp_us;
            end
        end
    end

    // Datapath, driven by the current control word.
    always_ff @(posedge i_clk) begin
        unique case (w_uop.op)
            OP_IDLE: begin
                if (w_in_xfer) begin
                    r_elapsed <= i_start_of_run ? '0 : (i_timestamp_us - r_origin);
                    r_neg     <= w_neg;
                    r_mag     <= w_mag_full[PCNT_W-1:0];
                    r_den     <= w_den;
                    r_tn      <= w_tn;
                end
            end
            OP_MUL: begin
                r_num   <= w_num;
                r_tprod <= w_tprod;
            end
            OP_DIV_INIT: begin
                r_rem <= DEN_W'(r_num[NUM_W-1:QUO_W]);
                r_quo <= r_num[QUO_W-1:0];
                r_tq  <= r_tprod[TPR_SH+TEMP_W-1:TPR_SH];
            end
            OP_DIV_STEP: begin
                r_rem <= w_rem_nx;
                r_quo <= {r_quo[QUO_W-2:0], w_ge};
            end
            OP_ROOT_INIT: begin
                r_x    <= ROOT_W'(r_quo);
                r_res  <= '0;
                r_bit  <= ROOT_W'(1) << (ROOT_W - 2);
                r_temp <= w_tq_fix - TEMP_BIAS;
            end
            OP_ROOT_STEP: begin
                if (w_take) begin
                    r_x   <= r_x - w_trial[ROOT_W-1:0];
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            OP_STORE: begin
                if (w_out_free) begin
                    r_out_elapsed <= r_elapsed;
                    r_out_speed   <= r_neg ? (SPEED_W'(0) - w_sat) : w_sat;
                    r_out_temp    <= r_temp;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_uop.op == OP_STORE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_elapsed_us          = r_out_elapsed;
    assign o_airspeed_cm_s       = r_out_speed;
    assign o_temperature_centi_c = r_out_temp;

endmodule

`default_nettype wire

FILE: hw/rtl/pac_checker.sv
// ----------------------------------------------------------------------------
// pac_checker
// Port-level checks for the pitot airspeed conversion unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pac_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    input  wire logic                              o_in_ready,
    input  wire logic                              o_out_valid,
    input  wire logic                              i_out_ready,
    input  wire logic [pac_pkg::TS_W-1:0]          o_elapsed_us,
    input  wire logic signed [pac_pkg::SPEED_W-1:0] o_airspeed_cm_s,
    input  wire logic signed [pac_pkg::TEMP_W-1:0]  o_temperature_centi_c
);
    import pac_pkg::*;

    // After reset the block is idle with nothing to deliver.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_in_ready && !o_out_valid))
        else $error("block not idle after reset");

    // One sample at a time: a transfer closes the input for the work that follows.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready ##1 !o_in_ready)
        else $error("input reopened too early after a transfer");

    // A stalled result stays and keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_elapsed_us) && $stable(o_airspeed_cm_s)
             && $stable(o_temperature_centi_c)))
        else $error("stalled result changed or dropped");

    // Delivered values stay inside the saturated speed and sensor ranges.
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_airspeed_cm_s >= -16'sd12000 && o_airspeed_cm_s <= 16'sd12000
             && o_temperature_centi_c >= -16'sd5000
             && o_temperature_centi_c <= 16'sd15000))
        else $error("result out of range");

endmodule

bind pitot_airspeed_conversion_unit pac_checker u_pac_checker (.*);

`default_nettype wire
